// File: hdl/sorted_best_time_table_defines.svh
// Assertion macros used by the checker file of the sorted best-time table.
`ifndef SORTED_BEST_TIME_TABLE_DEFINES_SVH
`define SORTED_BEST_TIME_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBTT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted best-time table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted best-time table check failed");

`endif

// File: hdl/sbtt_pkg.sv
// Package with the types and constants of the sorted best-time table.
`default_nettype none

package sbtt_pkg;

  localparam int unsigned TableDepthDefault = 10;
  localparam int unsigned TableDepthMax     = 64;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned IndexW = 6;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned STdataW = 40;
  localparam int unsigned MTdataW = 72;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRead   = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0]  tval;
    logic [StampW-1:0] stamp;
  } entry_t;

  // Control handed from one cell to the next.
  typedef struct packed {
    logic ins;    // an insert request is being accepted this cycle
    logic found;  // an earlier cell has already taken the new time
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/sorted_best_time_table.sv
// Sorted best-time table: a row of slot cells kept in ascending time order.
// A result is registered in the output register in the cycle after its request is taken.
// Throughput: one request per cycle while the input is not stalled; each cell compares and shifts in the same cycle.
// The input is stalled only while a finished result waits and the output side is stalled.
// Reset clears every slot to empty with stamp zero, the sequence counter and the output.
`default_nettype none

module sorted_best_time_table
  import sbtt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // time_value [31:0], entry_index [37:32], zero pad [39:38]
  input  wire logic [STdataW-1:0] s_axis_tdata,
  // mode [0]
  input  wire logic               s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // slot [5:0], stamp [37:6], entry_time [69:38], zero pad [71:70]
  output logic [MTdataW-1:0]      m_axis_tdata,
  // accepted [0]
  output logic                    m_axis_tuser
);

  logic              in_acc;
  logic              is_insert;
  logic [TimeW-1:0]  in_time;
  logic [IndexW-1:0] in_index;

  logic [StampW-1:0] counter_q, counter_d;
  entry_t            new_entry;

  entry_t     cell_entry [TABLE_DEPTH];
  cell_ctrl_t cell_ctrl  [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] cell_hit;

  logic              res_acc;
  logic [SlotW-1:0]  res_slot;
  logic [StampW-1:0] res_stamp;
  logic [TimeW-1:0]  res_time;

  logic              out_valid_q;
  logic              out_acc_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [StampW-1:0] out_stamp_q;
  logic [TimeW-1:0]  out_time_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_time       = s_axis_tdata[TimeW-1:0];
  assign in_index      = s_axis_tdata[TimeW +: IndexW];
  assign is_insert     = (s_axis_tuser == ModeInsert);

  assign new_entry.tval  = in_time;
  assign new_entry.stamp = counter_q + StampW'(1);

  assign cell_ctrl[0].ins   = in_acc && is_insert;
  assign cell_ctrl[0].found = 1'b0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t prev_entry;
    if (k == 0) begin : g_head
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_entry = cell_entry[k-1];
    end
    sbtt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[k]),
      .prev_i  (prev_entry),
      .new_i   (new_entry),
      .entry_o (cell_entry[k]),
      .ctrl_o  (cell_ctrl[k+1]),
      .hit_o   (cell_hit[k])
    );
  end

  // Encode the taking cell and select the read slot; at most one term is set in each.
  always_comb begin
    res_slot  = '0;
    res_stamp = '0;
    res_time  = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (cell_hit[k]) begin
        res_slot = res_slot | SlotW'(k);
      end
      if (!is_insert && (in_index == IndexW'(k))) begin
        res_stamp = res_stamp | cell_entry[k].stamp;
        res_time  = res_time | cell_entry[k].tval;
      end
    end
    res_acc = |cell_hit;
    if (res_acc) begin
      res_stamp = new_entry.stamp;
    end
  end

  assign counter_d = res_acc ? new_entry.stamp : counter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      counter_q <= counter_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_acc_q   <= 1'b0;
      out_slot_q  <= '0;
      out_stamp_q <= '0;
      out_time_q  <= '0;
    end else if (in_acc) begin
      out_acc_q   <= res_acc;
      out_slot_q  <= res_slot;
      out_stamp_q <= res_stamp;
      out_time_q  <= res_time;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_acc_q;
  assign m_axis_tdata  = {{(MTdataW - SlotW - StampW - TimeW){1'b0}},
                          out_time_q, out_stamp_q, out_slot_q};

endmodule

`default_nettype wire

// File: hdl/sbtt_cell.sv
// One table slot: holds a time and its stamp and takes part in the insert shift.
`default_nettype none

module sbtt_cell
  import sbtt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     prev_i,
  input  wire entry_t     new_i,
  output entry_t          entry_o,
  output cell_ctrl_t      ctrl_o,
  output logic            hit_o
);

  entry_t entry_q, entry_d;
  logic   qual;

  // An empty slot or a strictly larger time lets the new time in here.
  assign qual  = (entry_q.tval == '0) || (new_i.tval < entry_q.tval);
  assign hit_o = ctrl_i.ins && !ctrl_i.found && qual;

  assign ctrl_o.ins   = ctrl_i.ins;
  assign ctrl_o.found = ctrl_i.found || qual;

  always_comb begin
    entry_d = entry_q;
    if (hit_o) begin
      entry_d = new_i;
    end else if (ctrl_i.ins && ctrl_i.found) begin
      entry_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: hdl/sbtt_checker.sv
// Port-level checks for the sorted best-time table, bound to its top level.
`default_nettype none
`include "sorted_best_time_table_defines.svh"

module sbtt_checker
  import sbtt_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic [STdataW-1:0] s_axis_tdata,
  input wire logic               s_axis_tuser,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [MTdataW-1:0] m_axis_tdata,
  input wire logic               m_axis_tuser
);

  logic [SlotW-1:0] chk_slot;
  logic [TimeW-1:0] chk_time;

  assign chk_slot = m_axis_tdata[SlotW-1:0];
  assign chk_time = m_axis_tdata[SlotW+StampW +: TimeW];

  // Every taken request leaves a result in the output register.
  `SBTT_ASSERT_NEXT(a_req_gives_result, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // A waiting result is not overwritten.
  `SBTT_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // An accepted insert never carries a read time.
  `SBTT_ASSERT_IMPLY(a_insert_no_time, clk_i, rst_ni,
                     m_axis_tvalid && m_axis_tuser, chk_time == '0)

  // A result that did not enter the table reports slot zero.
  `SBTT_ASSERT_IMPLY(a_reject_slot_zero, clk_i, rst_ni,
                     m_axis_tvalid && !m_axis_tuser, chk_slot == '0)

  // A read request always results in a non-accepted result.
  `SBTT_ASSERT_NEXT(a_read_not_accepted, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ModeRead), !m_axis_tuser)

endmodule

bind sorted_best_time_table sbtt_checker u_sbtt_checker (.*);

`default_nettype wire
